[rtl/sdll_pkg.sv]
// ----------------------------------------------------------------------------
// sdll_pkg
// Shared types and constants of the synchronous demodulator with log level.
// ----------------------------------------------------------------------------
package sdll_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int ACC_BITS    = 32;
    localparam int TICK_BITS   = 8;
    localparam int HALF_BITS   = 7;
    localparam int SHIFT_BITS  = 4;
    localparam int LEVEL_BITS  = 7;
    localparam int TOP_BITS    = $clog2(ACC_BITS - 1);
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    localparam logic [SHIFT_BITS-1:0] DC_SHIFT_RESET     = SHIFT_BITS'(8);
    localparam logic [SHIFT_BITS-1:0] SMOOTH_SHIFT_RESET = SHIFT_BITS'(8);
    localparam logic [HALF_BITS-1:0]  HALF_PERIOD_RESET  = HALF_BITS'(11);
    localparam logic [LEVEL_BITS-1:0] LEVEL_OFFSET       = LEVEL_BITS'(8);

    typedef enum logic [1:0] {
        REG_DC_SHIFT     = 2'd0,
        REG_SMOOTH_SHIFT = 2'd1,
        REG_HALF_PERIOD  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

endpackage

[rtl/sdll_level.sv]
// ----------------------------------------------------------------------------
// sdll_level
// Log level of the integrator: top set bit of the negated value, offset by
// the integrator time constant; zero when the integrator is non-negative.
// ----------------------------------------------------------------------------
module sdll_level
    import sdll_pkg::*;
(
    input  logic [ACC_BITS-1:0]   accum,
    input  logic [SHIFT_BITS-1:0] smooth_shift,
    output logic [LEVEL_BITS-1:0] level
);

    logic [ACC_BITS-1:0] mag;
    logic [TOP_BITS-1:0] top;

    assign mag = ACC_BITS'(0) - accum;

    always_comb
    begin
        top = '0;
        for (int i = 0; i < ACC_BITS - 1; i++)
        begin
            if (mag[i])
            begin
                top = TOP_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (!accum[ACC_BITS-1])
        begin
            level = '0;
        end
        else
        begin
            level = LEVEL_BITS'(top) + LEVEL_OFFSET - LEVEL_BITS'(smooth_shift);
        end
    end

endmodule

[rtl/synchronous_demodulator_log_level_core.sv]
// ----------------------------------------------------------------------------
// synchronous_demodulator_log_level_core
// Square-carrier lock-in demodulator: DC-removing high-pass, carrier sign,
// leaky integrator and logarithmic level, with an APB-style register port.
// ----------------------------------------------------------------------------
// Throughput: 1 request per cycle unless result_stall holds a valid result;
//   the whole tick update, both accumulator updates and the level encode,
//   complete in the cycle of acceptance and are registered onto the output for the next cycle.
// Reset: rst_n clears counter, accumulators, drive, level and the valid flag,
//   and loads dc_shift = 8, smooth_shift = 8, half_period = 11.
// ----------------------------------------------------------------------------
module synchronous_demodulator_log_level_core
    import sdll_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready,

    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] adc_sample,
    input  logic                   laser_enable,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   drive_level,
    output logic                   demod_update,
    output logic [LEVEL_BITS-1:0]  log_level,
    output logic [ACC_BITS-1:0]    demod_value
);

    logic [SHIFT_BITS-1:0] dc_shift_reg;
    logic [SHIFT_BITS-1:0] smooth_shift_reg;
    logic [HALF_BITS-1:0]  half_period_reg;

    logic [TICK_BITS-1:0]  tick_reg,     tick_next;
    logic [ACC_BITS-1:0]   dc_accum_reg, dc_accum_next;
    logic [ACC_BITS-1:0]   smooth_reg,   smooth_next;
    logic                  drive_reg,    drive_next;
    logic [LEVEL_BITS-1:0] level_reg,    level_next;
    logic                  update_reg;
    logic                  valid_reg;

    logic                  cfg_write;
    reg_index_t            cfg_index;
    logic                  accept;

    logic [HALF_BITS-1:0]  hp;
    logic [TICK_BITS-1:0]  full_period;
    logic [TICK_BITS-1:0]  tick_inc;
    logic [TICK_BITS-1:0]  tick_wrap;
    logic                  period_hit;
    logic                  half_hit;
    logic                  run;

    logic [ACC_BITS-1:0]   dc_leak;
    logic [ACC_BITS-1:0]   smooth_leak;
    logic [ACC_BITS-1:0]   h1;
    logic [ACC_BITS-1:0]   demod_in;
    logic [ACC_BITS-1:0]   smooth_step;
    logic [LEVEL_BITS-1:0] level_calc;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[ADDR_BITS-1:2]);

    always_comb
    begin
        case (cfg_index)
            REG_DC_SHIFT:     prdata = DATA_BITS'(dc_shift_reg);
            REG_SMOOTH_SHIFT: prdata = DATA_BITS'(smooth_shift_reg);
            REG_HALF_PERIOD:  prdata = DATA_BITS'(half_period_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_shift_reg     <= DC_SHIFT_RESET;
            smooth_shift_reg <= SMOOTH_SHIFT_RESET;
            half_period_reg  <= HALF_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DC_SHIFT:     dc_shift_reg     <= pwdata[SHIFT_BITS-1:0];
                REG_SMOOTH_SHIFT: smooth_shift_reg <= pwdata[SHIFT_BITS-1:0];
                REG_HALF_PERIOD:  half_period_reg  <= pwdata[HALF_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // request handshake
    assign sample_stall = valid_reg && result_stall;
    assign accept       = sample_valid && !sample_stall;

    // carrier timing; zero half period counts as one
    assign hp          = (half_period_reg == '0) ? HALF_BITS'(1) : half_period_reg;
    assign full_period = {hp, 1'b0};
    assign tick_inc    = tick_reg + TICK_BITS'(1);
    assign period_hit  = tick_inc >= full_period;
    assign tick_wrap   = period_hit ? '0 : tick_inc;
    assign half_hit    = tick_wrap == TICK_BITS'(hp);
    assign run         = period_hit || half_hit;
    assign tick_next   = tick_wrap;

    always_comb
    begin
        drive_next = drive_reg;
        if (period_hit && laser_enable)
        begin
            drive_next = 1'b1;
        end
        if (half_hit)
        begin
            drive_next = 1'b0;
        end
    end

    // high-pass, carrier sign, leaky integrator
    assign dc_leak       = ACC_BITS'($signed(dc_accum_reg) >>> dc_shift_reg);
    assign smooth_leak   = ACC_BITS'($signed(smooth_reg) >>> smooth_shift_reg);
    assign h1            = ACC_BITS'(adc_sample) - dc_leak;
    assign dc_accum_next = run ? (dc_accum_reg + h1) : dc_accum_reg;
    assign demod_in      = half_hit ? (ACC_BITS'(0) - h1) : h1;
    assign smooth_step   = smooth_reg + demod_in - smooth_leak;
    assign smooth_next   = run ? smooth_step : smooth_reg;

    sdll_level u_level (
        .accum        (smooth_step),
        .smooth_shift (smooth_shift_reg),
        .level        (level_calc)
    );

    assign level_next = run ? level_calc : level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            dc_accum_reg <= '0;
            smooth_reg   <= '0;
            drive_reg    <= 1'b0;
            level_reg    <= '0;
            update_reg   <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tick_reg     <= tick_next;
                dc_accum_reg <= dc_accum_next;
                smooth_reg   <= smooth_next;
                drive_reg    <= drive_next;
                level_reg    <= level_next;
                update_reg   <= run;
                valid_reg    <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg    <= 1'b0;
            end
        end
    end

    // state registers change only with a new result, so they double as output
    assign result_valid = valid_reg;
    assign drive_level  = drive_reg;
    assign demod_update = update_reg;
    assign log_level    = level_reg;
    assign demod_value  = smooth_reg;

endmodule

[dv/tb_synchronous_demodulator_log_level_core.sv]
// ----------------------------------------------------------------------------
// tb_synchronous_demodulator_log_level_core
// Self-checking bench for the lock-in demodulator. A queue-fed driver sends
// sample tick requests and a monitor checks every result field against an
// in-bench model of the carrier counter, high-pass, integrator and level.
// The register port is reprogrammed between phases once the block is idle.
// ----------------------------------------------------------------------------
module tb_synchronous_demodulator_log_level_core;
    import sdll_pkg::*;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   laser;
    } tick_req_t;

    typedef struct packed {
        logic                  drive;
        logic                  update;
        logic [LEVEL_BITS-1:0] level;
        logic [ACC_BITS-1:0]   value;
    } demod_res_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_BITS-1:0]   paddr = '0;
    logic [DATA_BITS-1:0]   pwdata = '0;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    logic [SAMPLE_BITS-1:0] adc_sample = '0;
    logic                   laser_enable = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   drive_level;
    logic                   demod_update;
    logic [LEVEL_BITS-1:0]  log_level;
    logic [ACC_BITS-1:0]    demod_value;

    synchronous_demodulator_log_level_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .adc_sample   (adc_sample),
        .laser_enable (laser_enable),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drive_level  (drive_level),
        .demod_update (demod_update),
        .log_level    (log_level),
        .demod_value  (demod_value)
    );

    always #5 clk = ~clk;

    tick_req_t  ticks_pending[$];
    demod_res_t demod_results_due[$];
    int         fail_count = 0;
    int         idle_pct = 17;
    int         stall_pct = 17;

    // model configuration and state
    logic [SHIFT_BITS-1:0] cfg_dc_shift = DC_SHIFT_RESET;
    logic [SHIFT_BITS-1:0] cfg_smooth_shift = SMOOTH_SHIFT_RESET;
    logic [HALF_BITS-1:0]  cfg_half = HALF_PERIOD_RESET;
    logic [TICK_BITS-1:0]  st_tick = '0;
    logic [ACC_BITS-1:0]   st_dc = '0;
    logic [ACC_BITS-1:0]   st_smooth = '0;
    logic                  st_drive = 1'b0;
    logic [LEVEL_BITS-1:0] st_level = '0;

    function automatic void carrier_step(input logic [SAMPLE_BITS-1:0] s, input logic neg);
        logic signed [ACC_BITS-1:0] dc_part;
        logic signed [ACC_BITS-1:0] smooth_part;
        logic [ACC_BITS-1:0]        h1;
        logic [ACC_BITS-1:0]        d;
        logic [ACC_BITS-1:0]        mag;
        logic [LEVEL_BITS-1:0]      top;
        dc_part = $signed(st_dc) >>> cfg_dc_shift;
        h1 = ACC_BITS'(s) - dc_part;
        st_dc = st_dc + h1;
        d = neg ? -h1 : h1;
        smooth_part = $signed(st_smooth) >>> cfg_smooth_shift;
        st_smooth = st_smooth + (d - smooth_part);
        if (!st_smooth[ACC_BITS-1])
        begin
            st_level = '0;
        end
        else
        begin
            // most negative value negates to itself: no bit below the top
            mag = -st_smooth;
            top = '0;
            for (int i = 0; i < ACC_BITS - 1; i++)
            begin
                if (mag[i])
                    top = LEVEL_BITS'(i);
            end
            st_level = top - LEVEL_BITS'(cfg_smooth_shift) + LEVEL_OFFSET;
        end
    endfunction

    function automatic demod_res_t next_demod_result(input tick_req_t r);
        logic [TICK_BITS-1:0] hp;
        logic [TICK_BITS:0]   full;
        demod_res_t           o;
        hp = (cfg_half == '0) ? TICK_BITS'(1) : TICK_BITS'(cfg_half);
        full = {1'b0, hp} << 1;
        o.update = 1'b0;
        st_tick = st_tick + 1'b1;
        if ({1'b0, st_tick} >= full)
        begin
            if (r.laser)
                st_drive = 1'b1;
            st_tick = '0;
            carrier_step(r.sample, 1'b0);
            o.update = 1'b1;
        end
        if (st_tick == hp)
        begin
            st_drive = 1'b0;
            carrier_step(r.sample, 1'b1);
            o.update = 1'b1;
        end
        o.drive = st_drive;
        o.level = st_level;
        o.value = st_smooth;
        return o;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        tick_req_t nxt;
        if (sample_valid && !sample_stall)
            demod_results_due.push_back(next_demod_result(tick_req_t'({adc_sample, laser_enable})));
        if (!sample_valid || !sample_stall)
        begin
            if (rst_n && ticks_pending.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = ticks_pending.pop_front();
                sample_valid <= 1'b1;
                adc_sample   <= nxt.sample;
                laser_enable <= nxt.laser;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        demod_res_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (demod_results_due.size() == 0)
            begin
                $display("%0t unexpected result: drive %0d update %0d level %0d value %h",
                         $time, drive_level, demod_update, log_level, demod_value);
                fail_count++;
            end
            else
            begin
                e = demod_results_due.pop_front();
                if (drive_level !== e.drive)
                begin
                    $display("%0t drive_level exp %0d got %0d", $time, e.drive, drive_level);
                    fail_count++;
                end
                if (demod_update !== e.update)
                begin
                    $display("%0t demod_update exp %0d got %0d", $time, e.update, demod_update);
                    fail_count++;
                end
                if (log_level !== e.level)
                begin
                    $display("%0t log_level exp %0d got %0d", $time,
                             $signed(e.level), $signed(log_level));
                    fail_count++;
                end
                if (demod_value !== e.value)
                begin
                    $display("%0t demod_value exp %h got %h", $time, e.value, demod_value);
                    fail_count++;
                end
            end
        end
        result_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    task automatic wait_quiet();
        while (ticks_pending.size() != 0 || sample_valid || demod_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [HALF_BITS-1:0] val);
        logic [DATA_BITS-1:0] keep;
        keep = (idx == REG_HALF_PERIOD) ? DATA_BITS'(7'h7F) : DATA_BITS'(4'hF);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= (DATA_BITS'($urandom) & ~keep) | (DATA_BITS'(val) & keep);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DC_SHIFT:     cfg_dc_shift = val[SHIFT_BITS-1:0];
            REG_SMOOTH_SHIFT: cfg_smooth_shift = val[SHIFT_BITS-1:0];
            REG_HALF_PERIOD:  cfg_half = val;
            default:          ;
        endcase
    endtask

    task automatic queue_tick(input logic [SAMPLE_BITS-1:0] s, input logic en);
        ticks_pending.push_back(tick_req_t'({s, en}));
    endtask

    function automatic logic [HALF_BITS-1:0] pick_shift();
        case ($urandom_range(3))
            0:       return '0;
            1:       return HALF_BITS'(15);
            default: return HALF_BITS'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [HALF_BITS-1:0] pick_half();
        case ($urandom_range(11))
            0:       return '0;
            1:       return HALF_BITS'(1);
            2:       return HALF_BITS'(127);
            3:       return HALF_BITS'($urandom_range(1, 127));
            default: return HALF_BITS'($urandom_range(1, 12));
        endcase
    endfunction

    initial
    begin
        int                     n;
        int                     phase;
        int                     issued;
        int                     hpe;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] s;
        logic                   en;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings
        queue_tick(12'hFFF, 1'b1);
        queue_tick(12'h000, 1'b0);
        queue_tick(12'h800, 1'b1);
        wait_quiet();

        // shortest carrier, no filtering
        reg_write(REG_DC_SHIFT, '0);
        reg_write(REG_SMOOTH_SHIFT, '0);
        reg_write(REG_HALF_PERIOD, HALF_BITS'(1));
        queue_tick(12'hFFF, 1'b1);
        queue_tick(12'hFFF, 1'b1);
        queue_tick(12'h000, 1'b1);
        queue_tick(12'h000, 1'b0);
        queue_tick(12'hFFF, 1'b0);
        queue_tick(12'h000, 1'b1);
        wait_quiet();

        // longest time constants: level goes below zero
        reg_write(REG_SMOOTH_SHIFT, HALF_BITS'(15));
        reg_write(REG_DC_SHIFT, HALF_BITS'(15));
        queue_tick(12'hFFF, 1'b1);
        queue_tick(12'h000, 1'b1);
        queue_tick(12'hFFF, 1'b1);
        queue_tick(12'h000, 1'b1);
        wait_quiet();

        // zero half period acts as one; unused register slot
        reg_write(REG_HALF_PERIOD, '0);
        reg_write(REG_UNUSED, HALF_BITS'($urandom));
        queue_tick(12'h000, 1'b1);
        queue_tick(12'hFFF, 1'b0);
        queue_tick(12'h001, 1'b1);
        queue_tick(12'hFFE, 1'b1);
        wait_quiet();

        reg_write(REG_HALF_PERIOD, HALF_BITS'(127));
        reg_write(REG_DC_SHIFT, HALF_BITS'(8));
        reg_write(REG_SMOOTH_SHIFT, HALF_BITS'(8));
        queue_tick(12'hAAA, 1'b1);
        queue_tick(12'h555, 1'b0);
        queue_tick(12'hFFF, 1'b1);
        queue_tick(12'h000, 1'b0);

        phase = 0;
        issued = 0;
        while (issued < 1650)
        begin
            wait_quiet();
            reg_write(REG_DC_SHIFT, pick_shift());
            reg_write(REG_SMOOTH_SHIFT, pick_shift());
            reg_write(REG_HALF_PERIOD, pick_half());
            if (phase == 3 || $urandom_range(9) == 0)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct = 17;
                stall_pct = 17;
            end
            n = $urandom_range(40, 120);
            hpe = (cfg_half == '0) ? 1 : int'(cfg_half);
            hi = SAMPLE_BITS'($urandom_range(2048, 4095));
            lo = SAMPLE_BITS'($urandom_range(0, 2047));
            for (int k = 0; k < n; k++)
            begin
                case ($urandom_range(9))
                    0, 1:
                    begin
                        s = SAMPLE_BITS'($urandom);
                        en = 1'($urandom_range(1));
                    end
                    2:
                    begin
                        s = $urandom_range(1) ? '1 : '0;
                        en = 1'($urandom_range(1));
                    end
                    default:
                    begin
                        // square wave locked to the carrier, with a little noise
                        s = (((k / hpe) % 2) == 0 ? hi : lo) ^ SAMPLE_BITS'($urandom_range(63));
                        en = ($urandom_range(7) != 0);
                    end
                endcase
                queue_tick(s, en);
            end
            issued += n;
            phase++;
        end

        wait_quiet();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
